/* rtl/repeating_countdown_timer_defines.svh */
// Assertion macros for the repeating countdown timer.
// RTC_ASSERT_IMP: same-cycle implication, RTC_ASSERT_NXT: next-cycle implication.
`ifndef REPEATING_COUNTDOWN_TIMER_DEFINES_SVH
`define REPEATING_COUNTDOWN_TIMER_DEFINES_SVH

`ifndef SYNTHESIS
`define RTC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rtc assertion failed");
`define RTC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rtc assertion failed");
`else
`define RTC_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define RTC_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* rtl/rtc_pkg.sv */
`default_nettype none

package rtc_pkg;

    // transaction codes
    localparam logic [2:0] MODE_TICK    = 3'd0;
    localparam logic [2:0] MODE_START   = 3'd1;
    localparam logic [2:0] MODE_STOP    = 3'd2;
    localparam logic [2:0] MODE_PAUSE   = 3'd3;
    localparam logic [2:0] MODE_RESUME  = 3'd4;
    localparam logic [2:0] MODE_RESTART = 3'd5;
    localparam logic [2:0] MODE_FORCE   = 3'd6;

    localparam logic [1:0] ST_STOPPED = 2'd0;
    localparam logic [1:0] ST_RUNNING = 2'd1;
    localparam logic [1:0] ST_PAUSED  = 2'd2;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_LIMIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_SCALE   = 2'd2;

    localparam logic [15:0] TIME_SCALE_RST = 16'd256;

    typedef struct packed {
        logic [2:0]  mode;
        logic [15:0] delta;
    } t_in;

    typedef struct packed {
        logic        timeout;
        logic [1:0]  status;
        logic [31:0] remaining;
        logic [31:0] dispatch_count;
        logic        ever_dispatched;
    } t_out;

    typedef struct packed {
        logic [31:0]        interval;
        logic signed [16:0] repeat_limit;
        logic [15:0]        time_scale;
        logic               load;      // interval changed, reload time_left
    } t_cfg;

endpackage

`default_nettype wire

/* rtl/rtc_regs.sv */
`default_nettype none

module rtc_regs import rtc_pkg::*; #(
    parameter int TIME_WIDTH = 32
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_valid,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                       o_cfg
);

    localparam int LW = (TIME_WIDTH < 32) ? TIME_WIDTH : 32;

    logic [31:0]        r_interval, n_interval;
    logic signed [16:0] r_repeat_limit, n_repeat_limit;
    logic [15:0]        r_time_scale, n_time_scale;
    logic               r_load, n_load;
    logic [31:0]        w_new_interval;

    assign w_new_interval = 32'(i_cfg_data[LW-1:0]);

    always_comb begin
        n_interval     = r_interval;
        n_repeat_limit = r_repeat_limit;
        n_time_scale   = r_time_scale;
        n_load         = 1'b0;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_INTERVAL: begin
                    if (w_new_interval != r_interval) begin
                        n_interval = w_new_interval;
                        n_load     = 1'b1;
                    end
                end
                CFG_REPEAT_LIMIT: begin
                    // any negative value means forever
                    n_repeat_limit = i_cfg_data[16] ? -17'sd1 : {1'b0, i_cfg_data[15:0]};
                end
                CFG_TIME_SCALE: begin
                    if (i_cfg_data[15:0] != 16'd0) begin
                        n_time_scale = i_cfg_data[15:0];
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interval     <= '0;
            r_repeat_limit <= '0;
            r_time_scale   <= TIME_SCALE_RST;
            r_load         <= 1'b0;
        end else begin
            r_interval     <= n_interval;
            r_repeat_limit <= n_repeat_limit;
            r_time_scale   <= n_time_scale;
            r_load         <= n_load;
        end
    end

    assign o_cfg = '{interval: r_interval, repeat_limit: r_repeat_limit,
                     time_scale: r_time_scale, load: r_load};

endmodule

`default_nettype wire

/* rtl/rtc_ingress.sv */
`default_nettype none

// Input register: captures the transaction and the scaled elapsed time.
module rtc_ingress import rtc_pkg::*; #(
    parameter int SCALE_FRAC_BITS = 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire t_in               i_in,
    input  wire logic [15:0]       i_time_scale,
    input  wire logic              i_adv,
    output logic                   o_valid,
    output logic [2:0]             o_mode,
    output logic [31-SCALE_FRAC_BITS:0] o_scaled
);

    localparam int SW = 32 - SCALE_FRAC_BITS;

    logic          r_valid, n_valid;
    logic [2:0]    r_mode;
    logic [SW-1:0] r_scaled;
    logic [31:0]   w_product;
    logic          w_take;

    assign w_product  = 32'(i_in.delta) * 32'(i_time_scale);
    assign o_in_ready = !r_valid || i_adv;
    assign w_take     = i_in_valid && o_in_ready;

    always_comb begin
        n_valid = r_valid;
        if (w_take) begin
            n_valid = 1'b1;
        end else if (i_adv) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_mode   <= i_in.mode;
            r_scaled <= w_product[31:SCALE_FRAC_BITS];
        end
    end

    assign o_valid  = r_valid;
    assign o_mode   = r_mode;
    assign o_scaled = r_scaled;

endmodule

`default_nettype wire

/* rtl/rtc_core.sv */
`default_nettype none
`include "repeating_countdown_timer_defines.svh"

// Timer state and result register.
module rtc_core import rtc_pkg::*; #(
    parameter int TIME_WIDTH      = 32,
    parameter int SCALE_FRAC_BITS = 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_cfg              i_cfg,
    input  wire logic              i_valid,
    input  wire logic [2:0]        i_mode,
    input  wire logic [31-SCALE_FRAC_BITS:0] i_scaled,
    output logic                   o_adv,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output t_out                   o_out
);

    localparam int LW = (TIME_WIDTH < 32) ? TIME_WIDTH : 32;
    localparam int SW = 32 - SCALE_FRAC_BITS;
    localparam int CW = (LW > SW) ? LW : SW;

    logic [1:0]    r_run_state, n_run_state;
    logic [LW-1:0] r_time_left, n_time_left;
    logic [31:0]   r_fire_count, n_fire_count;
    logic          r_fired_flag, n_fired_flag;
    logic          r_out_valid, n_out_valid;
    t_out          r_out;
    logic          n_timeout;

    logic [LW-1:0] w_reload;
    logic [CW-1:0] w_left_x, w_scaled_x, w_diff;
    logic          w_expired;
    logic [31:0]   w_count_inc;
    logic          w_repeat;

    assign w_reload    = i_cfg.interval[LW-1:0];
    assign w_left_x    = CW'(r_time_left);
    assign w_scaled_x  = CW'(i_scaled);
    assign w_diff      = w_left_x - w_scaled_x;
    assign w_expired   = (w_left_x <= w_scaled_x);
    assign w_count_inc = (r_fire_count == '1) ? r_fire_count : r_fire_count + 32'd1;
    assign w_repeat    = i_cfg.repeat_limit[16] ||
                         ((i_cfg.repeat_limit != 17'sd0) &&
                          (w_count_inc <= 32'(i_cfg.repeat_limit[15:0])));

    assign o_adv = i_valid && (!r_out_valid || i_out_ready);

    always_comb begin
        n_run_state  = r_run_state;
        n_time_left  = r_time_left;
        n_fire_count = r_fire_count;
        n_fired_flag = r_fired_flag;
        n_timeout    = 1'b0;
        if (i_cfg.load) begin
            n_time_left = w_reload;
        end
        if (o_adv) begin
            case (i_mode)
                MODE_TICK: begin
                    if (r_run_state == ST_RUNNING) begin
                        if (w_expired) begin
                            // reload either way; repeat budget decides run or stop
                            n_timeout    = 1'b1;
                            n_fired_flag = 1'b1;
                            n_fire_count = w_count_inc;
                            n_time_left  = w_reload;
                            n_run_state  = w_repeat ? ST_RUNNING : ST_STOPPED;
                        end else begin
                            n_time_left = w_diff[LW-1:0];
                        end
                    end
                end
                MODE_START: begin
                    if (r_run_state == ST_STOPPED) begin
                        n_run_state  = ST_RUNNING;
                        n_fire_count = '0;
                    end else if (r_run_state == ST_PAUSED) begin
                        n_run_state = ST_RUNNING;
                    end else begin
                        n_time_left = w_reload;
                    end
                end
                MODE_STOP, MODE_FORCE: begin
                    if (r_run_state != ST_STOPPED) begin
                        n_timeout   = (i_mode == MODE_FORCE);
                        n_run_state = ST_STOPPED;
                        n_time_left = w_reload;
                    end
                end
                MODE_PAUSE: begin
                    if (r_run_state == ST_RUNNING) begin
                        n_run_state = ST_PAUSED;
                    end
                end
                MODE_RESUME: begin
                    if (r_run_state == ST_PAUSED) begin
                        n_run_state = ST_RUNNING;
                    end
                end
                MODE_RESTART: begin
                    n_run_state = ST_RUNNING;
                    if (r_run_state == ST_STOPPED) begin
                        n_fire_count = '0;
                    end else begin
                        n_time_left = w_reload;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_adv) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_state  <= ST_STOPPED;
            r_time_left  <= '0;
            r_fire_count <= '0;
            r_fired_flag <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_run_state  <= n_run_state;
            r_time_left  <= n_time_left;
            r_fire_count <= n_fire_count;
            r_fired_flag <= n_fired_flag;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv) begin
            r_out <= '{timeout: n_timeout, status: n_run_state,
                       remaining: 32'(n_time_left), dispatch_count: n_fire_count,
                       ever_dispatched: n_fired_flag};
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // a count can only exist after a tick timeout
    `RTC_ASSERT_IMP(a_count_implies_flag, i_clk, i_rst_n, r_fire_count != 32'd0, r_fired_flag)
    // sticky flag never drops outside reset
    `RTC_ASSERT_IMP(a_flag_sticky, i_clk, i_rst_n, $past(i_rst_n) && $past(r_fired_flag), r_fired_flag)
    // count moves by one step or clears on a fresh start
    `RTC_ASSERT_IMP(a_count_step, i_clk, i_rst_n, $past(i_rst_n), (r_fire_count == $past(r_fire_count)) || (r_fire_count == $past(r_fire_count) + 32'd1) || (r_fire_count == 32'd0))
    // every timeout leaves the timer reloaded
    `RTC_ASSERT_IMP(a_timeout_reloads, i_clk, i_rst_n, r_out_valid && r_out.timeout, r_out.remaining == 32'(w_reload))

endmodule

`default_nettype wire

/* rtl/repeating_countdown_timer.sv */
`default_nettype none

// Channel   Direction  Handshake                  Payload
// in        input      i_in_valid / o_in_ready    i_in  (t_in: mode, delta)
// out       output     o_out_valid / i_out_ready  o_out (t_out: timeout, status,
//                                                  remaining, dispatch_count,
//                                                  ever_dispatched)
// cfg       input      i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// Path: an input transaction goes through the input register, then the
// result register. One transaction per cycle sustained while i_out_ready is
// high; the limit is the state update (compare, subtract, reload) in rtc_core.
// Reset: synchronous, active low; timer stopped, time_left 0, interval 0,
// repeat limit 0, time scale 1.0.
// Stalls: o_in_ready drops only while both the input stage and the result
// register hold a transaction and i_out_ready is low. o_cfg_ready is always high.
module repeating_countdown_timer import rtc_pkg::*; #(
    parameter int TIME_WIDTH      = 32,
    parameter int SCALE_FRAC_BITS = 8
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // item input
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire t_in                   i_in,
    // result output
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output t_out                       o_out,
    // register writes
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int SW = 32 - SCALE_FRAC_BITS;

    t_cfg          w_cfg;
    logic          w_s1_valid;
    logic [2:0]    w_s1_mode;
    logic [SW-1:0] w_s1_scaled;
    logic          w_adv;

    // registers are written whenever offered
    assign o_cfg_ready = 1'b1;

    rtc_regs #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    // scale multiply happens on the way into the input register, so the
    // state update stage sees only a subtract and compare
    rtc_ingress #(
        .SCALE_FRAC_BITS (SCALE_FRAC_BITS)
    ) u_ingress (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in         (i_in),
        .i_time_scale (w_cfg.time_scale),
        .i_adv        (w_adv),
        .o_valid      (w_s1_valid),
        .o_mode       (w_s1_mode),
        .o_scaled     (w_s1_scaled)
    );

    rtc_core #(
        .TIME_WIDTH      (TIME_WIDTH),
        .SCALE_FRAC_BITS (SCALE_FRAC_BITS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_valid     (w_s1_valid),
        .i_mode      (w_s1_mode),
        .i_scaled    (w_s1_scaled),
        .o_adv       (w_adv),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire
